// ===== rtl/core/lsst_pkg.sv =====
`timescale 1ns / 1ps
// Package: shared types, codes and constants of the sweep sector tracker.
package lsst_pkg;

  // Configuration port geometry
  localparam int CFG_DATA_W = 16;
  localparam int CFG_IDX_W  = 3;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_CLOSE_THR   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_MIN_SIGNAL  = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_EXP_WIDTH   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_DEG_PER_SEC = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_HEAD_BIAS   = 3'd4;

  // Register reset values
  localparam logic [15:0] CLOSE_THR_RST  = 16'd52;
  localparam logic [15:0] MIN_SIGNAL_RST = 16'd600;
  localparam logic [8:0]  HEAD_BIAS_RST  = 9'd200;

  // Event codes on the result channel
  localparam logic [1:0] EV_TARGET       = 2'd0;
  localparam logic [1:0] EV_NO_TARGET    = 2'd1;
  localparam logic [1:0] EV_REHOME_WIDTH = 2'd2;
  localparam logic [1:0] EV_REHOME_OVFL  = 2'd3;

  // Rehome once the bad width count goes past this
  localparam logic [2:0] BAD_WIDTH_LIMIT = 3'd5;

  // Stored sector value: -1 bad status, 0 weak, else distance
  typedef logic signed [16:0] sval_t;

  // Controller to datapath
  typedef struct packed {
    logic load;
    logic eval;
    logic scan_step;
    logic head;
    logic emit;
  } ctl_cmd_t;

  // Datapath to controller
  typedef struct packed {
    logic search;
    logic emit_direct;
    logic scan_done;
    logic out_free;
  } ctl_sts_t;

endpackage

// ===== rtl/core/lsst_ifs.sv =====
`timescale 1ns / 1ps
// Interfaces: sample request channel and event request channel.
interface lsst_in_if;
  logic        valid;
  logic        ready;
  logic [15:0] distance_mm;
  logic [7:0]  range_status;
  logic [15:0] signal_per_spad;
  logic [31:0] time_ms;

  modport source (output valid, distance_mm, range_status, signal_per_spad, time_ms,
                  input ready);
  modport sink (input valid, distance_mm, range_status, signal_per_spad, time_ms,
                output ready);
endinterface

interface lsst_out_if;
  logic               valid;
  logic               ready;
  logic [1:0]         event_kind;
  logic signed [12:0] heading_offset_deg;
  logic [15:0]        target_range_mm;
  logic [5:0]         target_sector;

  modport source (output valid, event_kind, heading_offset_deg, target_range_mm,
                  target_sector, input ready);
  modport sink (input valid, event_kind, heading_offset_deg, target_range_mm,
                target_sector, output ready);
endinterface

// ===== rtl/core/lidar_sweep_sector_tracker_core.sv =====
`timescale 1ns / 1ps
// Top level: sweep sector tracker, controller plus datapath.
//
// Usage:
//   in_ch carries one range sample per request (distance, status, signal,
//   millisecond timestamp). out_ch carries at most one event per sample:
//   target found, no target, or a rehome request. cfg_we/cfg_index/cfg_wdata
//   write the threshold, signal floor, expected width, degrees per sector and
//   heading bias registers; write them only while the block is idle.
//   Timing: one sample at a time. A sample is accepted in idle and evaluated
//   in the next cycle; a sample that causes no event frees the input once evaluated.
//   Rehome events and no-target with fewer than two sectors go from the
//   evaluation straight to the emit step. On entering the backstop with two
//   or more stored sectors the scan reads the sector RAM one entry per cycle
//   over N entries, N the number of stored sectors (up to SECTORS), then the
//   heading step runs before the emit. The single RAM read port sets that rate.
//   Reset: synchronous, active low; registers take their defaults and the
//   tracking state clears. The sector RAM needs no clearing pass.
//   Stall: the event sits in an output register until taken; the next
//   sample is still accepted and evaluated, and only a second event waits.
module lidar_sweep_sector_tracker_core #(
  parameter int SECTORS = 64
) (
  input  logic                            clk,
  input  logic                            rst_n,
  lsst_in_if.sink                         in_ch,
  lsst_out_if.source                      out_ch,
  input  logic                            cfg_we,
  input  logic [lsst_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [lsst_pkg::CFG_DATA_W-1:0] cfg_wdata
);

  lsst_pkg::ctl_cmd_t cmd;
  lsst_pkg::ctl_sts_t sts;

  // sequencing
  lsst_ctrl u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .cmd      (cmd),
    .sts      (sts)
  );

  // storage and arithmetic
  lsst_dpath #(
    .SECTORS (SECTORS)
  ) u_dpath (
    .clk                    (clk),
    .rst_n                  (rst_n),
    .cfg_we                 (cfg_we),
    .cfg_index              (cfg_index),
    .cfg_wdata              (cfg_wdata),
    .in_distance_mm         (in_ch.distance_mm),
    .in_range_status        (in_ch.range_status),
    .in_signal_per_spad     (in_ch.signal_per_spad),
    .in_time_ms             (in_ch.time_ms),
    .out_valid              (out_ch.valid),
    .out_ready              (out_ch.ready),
    .out_event_kind         (out_ch.event_kind),
    .out_heading_offset_deg (out_ch.heading_offset_deg),
    .out_target_range_mm    (out_ch.target_range_mm),
    .out_target_sector      (out_ch.target_sector),
    .cmd                    (cmd),
    .sts                    (sts)
  );

endmodule

// ===== rtl/core/lsst_ram.sv =====
`timescale 1ns / 1ps
// Generic single-port-write, single-port-read RAM with registered read data.
module lsst_ram #(
  parameter int WIDTH = 17,
  parameter int DEPTH = 64
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== rtl/core/lsst_ctrl.sv =====
`timescale 1ns / 1ps
// Controller: sequences load, evaluate, sector scan, heading and emit.
module lsst_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_ready,
  output lsst_pkg::ctl_cmd_t cmd,
  input  lsst_pkg::ctl_sts_t sts
);

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_EVAL = 3'd1;
  localparam logic [2:0] S_SCAN = 3'd2;
  localparam logic [2:0] S_HEAD = 3'd3;
  localparam logic [2:0] S_EMIT = 3'd4;

  logic [2:0] state_r;
  logic [2:0] state_nxt;

  // next state and commands
  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    in_ready  = (state_r == S_IDLE);
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          cmd.load  = 1'b1;
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        cmd.eval = 1'b1;
        if (sts.search) begin
          state_nxt = S_SCAN;
        end else if (sts.emit_direct) begin
          state_nxt = S_EMIT;
        end else begin
          state_nxt = S_IDLE;
        end
      end
      S_SCAN: begin
        cmd.scan_step = 1'b1;
        if (sts.scan_done) begin
          state_nxt = S_HEAD;
        end
      end
      S_HEAD: begin
        cmd.head  = 1'b1;
        state_nxt = S_EMIT;
      end
      S_EMIT: begin
        if (sts.out_free) begin
          cmd.emit  = 1'b1;
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // an accepted request is always evaluated on the next cycle
  a_accept_then_eval: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> (state_r == S_EVAL))
    else $error("accepted request not evaluated");

  // the output register is never overwritten while it still holds a result
  a_emit_when_free: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.emit |-> sts.out_free)
    else $error("emit while output register busy");

  // only one request in flight: no load outside idle
  a_load_idle: assert property (@(posedge clk) disable iff (!rst_n)
    cmd.load |-> (state_r == S_IDLE))
    else $error("load outside idle");

endmodule

// ===== rtl/core/lsst_dpath.sv =====
`timescale 1ns / 1ps
// Datapath: config registers, tracking state, sector RAM, scan and result register.
module lsst_dpath #(
  parameter int SECTORS = 64
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // configuration
  input  logic                                cfg_we,
  input  logic [lsst_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [lsst_pkg::CFG_DATA_W-1:0]     cfg_wdata,
  // sample payload
  input  logic [15:0]                         in_distance_mm,
  input  logic [7:0]                          in_range_status,
  input  logic [15:0]                         in_signal_per_spad,
  input  logic [31:0]                         in_time_ms,
  // event register
  output logic                                out_valid,
  input  logic                                out_ready,
  output logic [1:0]                          out_event_kind,
  output logic signed [12:0]                  out_heading_offset_deg,
  output logic [15:0]                         out_target_range_mm,
  output logic [5:0]                          out_target_sector,
  // control
  input  lsst_pkg::ctl_cmd_t                  cmd,
  output lsst_pkg::ctl_sts_t                  sts
);

  localparam int IW = $clog2(SECTORS);
  localparam int CW = $clog2(SECTORS + 1);
  localparam int PW = 14 + IW;

  // configuration registers
  logic [15:0] close_thr_r;
  logic [15:0] min_signal_r;
  logic [15:0] exp_width_r;
  logic [13:0] deg_per_sec_r;
  logic [8:0]  head_bias_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      close_thr_r   <= lsst_pkg::CLOSE_THR_RST;
      min_signal_r  <= lsst_pkg::MIN_SIGNAL_RST;
      exp_width_r   <= '0;
      deg_per_sec_r <= '0;
      head_bias_r   <= lsst_pkg::HEAD_BIAS_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        lsst_pkg::CFG_CLOSE_THR:   close_thr_r   <= cfg_wdata;
        lsst_pkg::CFG_MIN_SIGNAL:  min_signal_r  <= cfg_wdata;
        lsst_pkg::CFG_EXP_WIDTH:   exp_width_r   <= cfg_wdata;
        lsst_pkg::CFG_DEG_PER_SEC: deg_per_sec_r <= cfg_wdata[13:0];
        lsst_pkg::CFG_HEAD_BIAS:   head_bias_r   <= cfg_wdata[8:0];
        default: ;
      endcase
    end
  end

  // captured sample
  logic [15:0] dist_r;
  logic [7:0]  status_r;
  logic [15:0] signal_r;
  logic [31:0] time_r;

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      dist_r   <= in_distance_mm;
      status_r <= in_range_status;
      signal_r <= in_signal_per_spad;
      time_r   <= in_time_ms;
    end
  end

  // tracking state
  logic [15:0]   last_raw_r, last_raw_nxt;
  logic          in_bs_r, in_bs_nxt;
  logic [31:0]   bs_start_r, bs_start_nxt;
  logic [2:0]    bad_cnt_r, bad_cnt_nxt;
  logic [CW-1:0] sec_cnt_r, sec_cnt_nxt;
  logic [1:0]    res_kind_r, res_kind_nxt;

  // sample classification
  logic                dup;
  lsst_pkg::sval_t     value;
  logic                backstop;
  logic [31:0]         width;
  logic                bad;
  logic [2:0]          bad_inc;
  logic                entering;
  logic                leaving;
  logic                rehome_w;
  logic                ovfl;
  logic                store;
  logic [CW-1:0]       eff_cnt;

  always_comb begin
    dup = (dist_r == last_raw_r);
    if (status_r != 8'd0) begin
      value = -17'sd1;
    end else if (signal_r < min_signal_r) begin
      value = '0;
    end else begin
      value = lsst_pkg::sval_t'({1'b0, dist_r});
    end
    backstop = (status_r == 8'd0) && (signal_r >= min_signal_r) &&
               (dist_r != 16'd0) && (dist_r <= close_thr_r);
    width    = time_r - bs_start_r;
    bad      = (width > 32'({exp_width_r, 1'b0})) || (width < 32'(exp_width_r[15:1]));
    bad_inc  = bad_cnt_r + {2'b00, bad};
    entering = !dup && backstop && !in_bs_r;
    leaving  = !dup && !backstop && in_bs_r;
    rehome_w = leaving && (bad_inc > lsst_pkg::BAD_WIDTH_LIMIT);
    eff_cnt  = leaving ? '0 : sec_cnt_r;
    ovfl     = !dup && !backstop && !rehome_w && (eff_cnt == CW'(SECTORS));
    store    = !dup && !backstop && !rehome_w && !ovfl;
  end

  // state update on evaluate
  always_comb begin
    last_raw_nxt = last_raw_r;
    in_bs_nxt    = in_bs_r;
    bs_start_nxt = bs_start_r;
    bad_cnt_nxt  = bad_cnt_r;
    sec_cnt_nxt  = sec_cnt_r;
    res_kind_nxt = res_kind_r;
    if (cmd.eval) begin
      if (!dup) begin
        last_raw_nxt = dist_r;
      end
      if (entering) begin
        in_bs_nxt    = 1'b1;
        bs_start_nxt = time_r;
      end
      if (leaving) begin
        in_bs_nxt   = 1'b0;
        bad_cnt_nxt = bad_inc;
        sec_cnt_nxt = '0;
      end
      if (rehome_w || ovfl) begin
        in_bs_nxt    = 1'b0;
        bs_start_nxt = '0;
        bad_cnt_nxt  = '0;
        sec_cnt_nxt  = '0;
      end
      if (store) begin
        sec_cnt_nxt = eff_cnt + CW'(1);
      end
      if (rehome_w) begin
        res_kind_nxt = lsst_pkg::EV_REHOME_WIDTH;
      end else if (ovfl) begin
        res_kind_nxt = lsst_pkg::EV_REHOME_OVFL;
      end else begin
        res_kind_nxt = lsst_pkg::EV_TARGET;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      last_raw_r <= '0;
      in_bs_r    <= 1'b0;
      bs_start_r <= '0;
      bad_cnt_r  <= '0;
      sec_cnt_r  <= '0;
      res_kind_r <= lsst_pkg::EV_TARGET;
    end else begin
      last_raw_r <= last_raw_nxt;
      in_bs_r    <= in_bs_nxt;
      bs_start_r <= bs_start_nxt;
      bad_cnt_r  <= bad_cnt_nxt;
      sec_cnt_r  <= sec_cnt_nxt;
      res_kind_r <= res_kind_nxt;
    end
  end

  assign sts.search      = entering && (sec_cnt_r >= CW'(2));
  assign sts.emit_direct = (entering && (sec_cnt_r < CW'(2))) || rehome_w || ovfl;

  // sector store
  logic [IW-1:0] scan_addr_r;
  logic          issuing_r;
  logic          ram_re;
  logic [16:0]   ram_rdata;

  assign ram_re = cmd.scan_step && issuing_r;

  lsst_ram #(
    .WIDTH (17),
    .DEPTH (SECTORS)
  ) u_sector_ram (
    .clk   (clk),
    .we    (cmd.eval && store),
    .waddr (eff_cnt[IW-1:0]),
    .wdata (value),
    .re    (ram_re),
    .raddr (scan_addr_r),
    .rdata (ram_rdata)
  );

  // sector scan: one read issued and one compare per cycle
  logic            dv_r;
  logic [IW-1:0]   dv_idx_r;
  lsst_pkg::sval_t prev_r;
  lsst_pkg::sval_t best_r;
  logic [IW-1:0]   best_idx_r;
  logic            found_r;
  logic [CW-1:0]   last_idx;
  lsst_pkg::sval_t rd_val;

  assign last_idx      = sec_cnt_r - CW'(1);
  assign rd_val        = lsst_pkg::sval_t'(ram_rdata);
  assign sts.scan_done = dv_r && (CW'(dv_idx_r) == last_idx);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      issuing_r <= 1'b0;
      dv_r      <= 1'b0;
    end else if (cmd.eval) begin
      issuing_r <= 1'b1;
      dv_r      <= 1'b0;
    end else if (cmd.scan_step) begin
      dv_r <= issuing_r;
      if (issuing_r && (CW'(scan_addr_r) == last_idx)) begin
        issuing_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.eval) begin
      scan_addr_r <= '0;
      prev_r      <= '0;
      best_r      <= '0;
      best_idx_r  <= '0;
      found_r     <= 1'b0;
    end else if (cmd.scan_step) begin
      dv_idx_r <= scan_addr_r;
      if (issuing_r && (CW'(scan_addr_r) != last_idx)) begin
        scan_addr_r <= scan_addr_r + IW'(1);
      end
      if (dv_r) begin
        // first strictly larger value with a positive left neighbour
        if ((dv_idx_r != '0) && (rd_val > best_r) && (prev_r > 17'sd0)) begin
          best_r     <= rd_val;
          best_idx_r <= dv_idx_r;
          found_r    <= 1'b1;
        end
        prev_r <= rd_val;
      end
    end
  end

  // heading product, registered before the bias subtract
  logic [PW-1:0] prod_r;

  always_ff @(posedge clk) begin
    if (cmd.head) begin
      prod_r <= PW'(deg_per_sec_r) * PW'(best_idx_r);
    end
  end

  logic [31:0] prod_ext;
  logic [31:0] idx_ext;
  logic [12:0] head_raw;

  assign prod_ext = 32'(prod_r);
  assign idx_ext  = 32'(best_idx_r);
  assign head_raw = prod_ext[20:8] - {4'b0000, head_bias_r};

  // output register
  logic               out_valid_r;
  logic [1:0]         out_kind_r;
  logic signed [12:0] out_head_r;
  logic [15:0]        out_range_r;
  logic [5:0]         out_sector_r;

  assign sts.out_free = !out_valid_r || out_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (cmd.emit) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      if ((res_kind_r == lsst_pkg::EV_TARGET) && found_r) begin
        out_kind_r   <= lsst_pkg::EV_TARGET;
        out_head_r   <= $signed(head_raw);
        out_range_r  <= best_r[15:0];
        out_sector_r <= idx_ext[5:0];
      end else begin
        out_kind_r   <= (res_kind_r == lsst_pkg::EV_TARGET) ? lsst_pkg::EV_NO_TARGET
                                                            : res_kind_r;
        out_head_r   <= '0;
        out_range_r  <= '0;
        out_sector_r <= '0;
      end
    end
  end

  assign out_valid              = out_valid_r;
  assign out_event_kind         = out_kind_r;
  assign out_heading_offset_deg = out_head_r;
  assign out_target_range_mm    = out_range_r;
  assign out_target_sector      = out_sector_r;

  // sector count never passes the store depth
  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    sec_cnt_r <= CW'(SECTORS))
    else $error("sector count past depth");

  // bad width count is cleared by the rehome before it can pass the limit
  a_bad_bound: assert property (@(posedge clk) disable iff (!rst_n)
    bad_cnt_r <= lsst_pkg::BAD_WIDTH_LIMIT)
    else $error("bad width count past limit");

  // the scan only reads sectors written since the last clear
  a_read_written: assert property (@(posedge clk) disable iff (!rst_n)
    ram_re |-> (CW'(scan_addr_r) < sec_cnt_r))
    else $error("scan reads unwritten sector");

endmodule
